// File: design/pccl_pkg.sv
// Shared types and constants of the palette color-cycling lookup.
package pccl_pkg;

  localparam int unsigned PALETTE_ENTRIES = 256;
  localparam int unsigned IDX_W = 8;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned OCC_W = $clog2(PALETTE_ENTRIES + 1);

  localparam logic [IDX_W-1:0] CYCLE_FIRST_RESET = 8'd133;
  localparam logic [IDX_W-1:0] CYCLE_LAST_RESET = 8'd143;
  localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 8'd255;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_ROTATE = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_e;

  typedef enum logic [0:0] {
    CFG_CYCLE_FIRST = 1'b0,
    CFG_CYCLE_LAST  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DRAIN,
    ST_SWAP
  } state_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [IDX_W-1:0]   entry_index;
    logic [COLOR_W-1:0] red_in;
    logic [COLOR_W-1:0] green_in;
    logic [COLOR_W-1:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] blue_out;
    logic [COLOR_W-1:0] green_out;
    logic [COLOR_W-1:0] red_out;
    logic [COLOR_W-1:0] alpha_out;
  } out_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  // Item traveling up the row of cells: a write carries its color, a lookup
  // picks the color up at the cell whose index matches.
  typedef struct packed {
    logic             valid;
    logic             lookup;
    logic [IDX_W-1:0] idx;
    rgb_t             rgb;
  } chain_item_t;

  typedef struct packed {
    logic             advance;
    logic             swap_start;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } chain_ctrl_t;

endpackage

// File: design/pccl_cell.sv
// One palette cell: holds one entry and one stage of the item row.
module pccl_cell
  import pccl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] cell_id_i,
  input  chain_ctrl_t      ctrl_i,
  input  chain_item_t      item_i,
  output chain_item_t      item_o,
  input  logic             tok_above_i,
  input  logic             tok_below_i,
  output logic             tok_o,
  input  rgb_t             entry_above_i,
  input  rgb_t             entry_below_i,
  output rgb_t             entry_o
);

  rgb_t        entry_q, entry_d;
  chain_item_t item_q, item_d;
  logic        tok_q, tok_d;
  logic        hit;

  assign hit = item_i.valid && (item_i.idx == cell_id_i);

  always_comb begin
    entry_d = entry_q;
    item_d  = item_q;
    if (ctrl_i.advance) begin
      item_d = item_i;
      if (hit && item_i.lookup) begin
        item_d.rgb = entry_q;
      end
      if (hit && !item_i.lookup) begin
        entry_d = item_i.rgb;
      end
    end
    // Swap with the upper neighbor while holding the token, or with the
    // lower one while it holds it.
    if (tok_q) begin
      entry_d = entry_above_i;
    end else if (tok_below_i) begin
      entry_d = entry_below_i;
    end
  end

  // Token starts just below the range end and walks down to the range start.
  assign tok_d = (ctrl_i.swap_start && (cell_id_i == ctrl_i.hi - IDX_W'(1))) ||
                 (tok_above_i && (cell_id_i >= ctrl_i.lo));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      item_q  <= '0;
      tok_q   <= 1'b0;
    end else begin
      entry_q <= entry_d;
      item_q  <= item_d;
      tok_q   <= tok_d;
    end
  end

  assign item_o  = item_q;
  assign tok_o   = tok_q;
  assign entry_o = entry_q;

endmodule

// File: design/pccl_chain.sv
// Row of palette cells, one per entry, linked to their neighbors.
module pccl_chain
  import pccl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  chain_ctrl_t ctrl_i,
  input  chain_item_t item_i,
  output chain_item_t item_o
);

  chain_item_t items [PALETTE_ENTRIES+1];
  logic        toks  [PALETTE_ENTRIES+2];
  rgb_t        ents  [PALETTE_ENTRIES+2];

  // Slot 0 and the last slot of toks and ents are the open ends of the row.
  assign items[0]                 = item_i;
  assign toks[0]                  = 1'b0;
  assign toks[PALETTE_ENTRIES+1]  = 1'b0;
  assign ents[0]                  = '0;
  assign ents[PALETTE_ENTRIES+1]  = '0;

  for (genvar k = 0; k < PALETTE_ENTRIES; k++) begin : g_cell
    pccl_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cell_id_i     (IDX_W'(k)),
      .ctrl_i        (ctrl_i),
      .item_i        (items[k]),
      .item_o        (items[k+1]),
      .tok_above_i   (toks[k+2]),
      .tok_below_i   (toks[k]),
      .tok_o         (toks[k+1]),
      .entry_above_i (ents[k+2]),
      .entry_below_i (ents[k]),
      .entry_o       (ents[k+1])
    );
  end

  assign item_o = items[PALETTE_ENTRIES];

endmodule

// File: design/palette_color_cycling_lookup_top.sv
// Top level of the palette color-cycling lookup: control, config and output.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-------------------------
//   in       | in_valid_i / in_stall_o  | in_item_i  (in_item_t)
//   out      | out_valid_o / out_stall_i| out_item_o (out_item_t)
//   config   | cfg_we_i                 | cfg_index_i, cfg_data_i
//
// Writes and lookups enter one per cycle when in_stall_o is low and travel
// through one cell stage per entry; a lookup result is then registered in the
// output register. A rotate first drains the cell row, then swaps neighbors
// down the range from last to first; intake holds meanwhile.
// Reset clears every palette entry at once; no clearing pass.
// A stalled output with a result waiting freezes the items in the row and intake.
module palette_color_cycling_lookup_top
  import pccl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o,
  input  logic             cfg_we_i,
  input  cfg_idx_e         cfg_index_i,
  input  logic [IDX_W-1:0] cfg_data_i
);

  logic [IDX_W-1:0] cycle_first_q, cycle_last_q;
  logic [IDX_W-1:0] rot_lo_q, rot_hi_q;
  logic [IDX_W-1:0] swap_cnt_q, swap_cnt_d;
  logic [IDX_W-1:0] last_clamped;
  logic [OCC_W-1:0] occ_q, occ_d;
  state_e           state_q, state_d;
  logic             advance, accept, enters, rot_go, swap_start;
  logic             out_valid_q;
  out_item_t        out_q;
  chain_ctrl_t      ctrl;
  chain_item_t      chain_in, chain_out;

  assign last_clamped = ({1'b0, cycle_last_q} >= (IDX_W+1)'(PALETTE_ENTRIES)) ?
                        IDX_W'(PALETTE_ENTRIES - 1) : cycle_last_q;

  assign advance = !(out_valid_q && out_stall_i);
  assign accept  = in_valid_i && !in_stall_o;
  assign enters  = accept && ((in_item_i.command == CMD_WRITE) ||
                              (in_item_i.command == CMD_LOOKUP));
  assign rot_go  = accept && (in_item_i.command == CMD_ROTATE) &&
                   (last_clamped > cycle_first_q);

  always_comb begin
    state_d    = state_q;
    swap_start = 1'b0;
    in_stall_o = 1'b1;
    swap_cnt_d = swap_cnt_q;
    case (state_q)
      ST_RUN: begin
        in_stall_o = !advance;
        if (rot_go) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (occ_q == '0) begin
          swap_start = 1'b1;
          swap_cnt_d = rot_hi_q - rot_lo_q;
          state_d    = ST_SWAP;
        end
      end
      ST_SWAP: begin
        swap_cnt_d = swap_cnt_q - IDX_W'(1);
        if (swap_cnt_q == IDX_W'(1)) begin
          state_d = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_comb begin
    occ_d = occ_q;
    if (enters && !(advance && chain_out.valid)) begin
      occ_d = occ_q + OCC_W'(1);
    end else if (!enters && advance && chain_out.valid) begin
      occ_d = occ_q - OCC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_RUN;
      cycle_first_q <= CYCLE_FIRST_RESET;
      cycle_last_q  <= CYCLE_LAST_RESET;
      occ_q         <= '0;
      swap_cnt_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      occ_q      <= occ_d;
      swap_cnt_q <= swap_cnt_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_CYCLE_FIRST: cycle_first_q <= cfg_data_i;
          CFG_CYCLE_LAST:  cycle_last_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (advance) begin
        out_valid_q <= chain_out.valid && chain_out.lookup;
      end
    end
  end

  // Latch the range so the swap walk sees a fixed window.
  always_ff @(posedge clk_i) begin
    if (rot_go) begin
      rot_lo_q <= cycle_first_q;
      rot_hi_q <= last_clamped;
    end
    if (advance) begin
      out_q.blue_out  <= chain_out.rgb.blue;
      out_q.green_out <= chain_out.rgb.green;
      out_q.red_out   <= chain_out.rgb.red;
      out_q.alpha_out <= ALPHA_OPAQUE;
    end
  end

  always_comb begin
    chain_in.valid     = enters;
    chain_in.lookup    = (in_item_i.command == CMD_LOOKUP);
    chain_in.idx       = in_item_i.entry_index;
    chain_in.rgb.red   = (in_item_i.command == CMD_LOOKUP) ? '0 : in_item_i.red_in;
    chain_in.rgb.green = (in_item_i.command == CMD_LOOKUP) ? '0 : in_item_i.green_in;
    chain_in.rgb.blue  = (in_item_i.command == CMD_LOOKUP) ? '0 : in_item_i.blue_in;
    ctrl.advance       = advance;
    ctrl.swap_start    = swap_start;
    ctrl.lo            = rot_lo_q;
    ctrl.hi            = rot_hi_q;
  end

  pccl_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .item_i (chain_in),
    .item_o (chain_out)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
